// ===== hw/rtl/bpt_pkg.sv =====
// Shared types and constants for the byte-level pre-tokenizer.
// Used by the front end, the range queue, the output stage and the top level.
package bpt_pkg;

    localparam int POS_W          = 16;
    localparam int MAX_TEXT_BYTES = 65535;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_TEXT_BYTES);

    typedef logic [POS_W-1:0] t_pos;

    typedef enum logic [2:0] {
        KIND_NONE          = 3'd0,
        KIND_UTF8          = 3'd1,
        KIND_SPACE_LETTERS = 3'd2,
        KIND_WHITESPACE    = 3'd3,
        KIND_LETTERS       = 3'd4,
        KIND_OTHER         = 3'd5
    } t_kind;

    // All ranges caused by one input byte.
    typedef struct packed {
        logic two;
        t_pos start0;
        t_pos end0;
        t_pos start1;
        t_pos end1;
    } t_entry;

endpackage

// ===== hw/rtl/bpt_front.sv =====
// Front end of the pre-tokenizer: classifies each byte and tracks the open group.
// Produces one queue entry with one or two ranges per byte that closes a group.
// Depends on bpt_pkg.
module bpt_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_byte,
    input  logic           i_eot,
    output logic           o_push,
    output bpt_pkg::t_entry o_entry
);
    import bpt_pkg::*;

    localparam logic [7:0] LEAD_MIN  = 8'h80;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD4_MIN = 8'hF0;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_APOS   = 8'h27;

    function automatic logic is_alpha_byte(input logic [7:0] b);
        is_alpha_byte = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic logic is_space_class(input logic [7:0] b);
        is_space_class = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        is_digit = (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_other(input logic [7:0] b);
        is_other = (b < LEAD_MIN) && !is_space_class(b) && !is_alpha_byte(b) &&
                   (b != CH_APOS) && !is_digit(b);
    endfunction

    function automatic logic continues(input t_kind k, input logic [7:0] b);
        case (k)
            KIND_SPACE_LETTERS: continues = is_alpha_byte(b);
            KIND_WHITESPACE:    continues = is_space_class(b);
            KIND_LETTERS:       continues = is_alpha_byte(b) || (b == CH_APOS);
            KIND_OTHER:         continues = is_other(b);
            default:            continues = 1'b0;
        endcase
    endfunction

    t_pos        r_pos,   n_pos;
    t_pos        r_start, n_start;
    t_kind       r_kind,  n_kind;
    logic [1:0]  r_left,  n_left;
    logic        r_space, n_space;

    t_pos        pe;
    logic [1:0]  cnt;
    logic        taken;
    t_entry      ent;

    always_comb begin
        pe      = (r_pos >= POS_MAX) ? POS_MAX : r_pos + POS_W'(1);
        n_pos   = r_pos;
        n_start = r_start;
        n_kind  = r_kind;
        n_left  = r_left;
        n_space = r_space;
        cnt     = 2'd0;
        taken   = 1'b0;
        ent     = '0;

        if (r_left != 2'd0) begin
            n_left = r_left - 2'd1;
            if (n_left == 2'd0) begin
                ent.start0 = r_start;
                ent.end0   = pe;
                cnt        = 2'd1;
                n_kind     = KIND_NONE;
            end
        end else begin
            if (r_space) begin
                n_space = 1'b0;
                n_kind  = is_alpha_byte(i_byte) ? KIND_SPACE_LETTERS : KIND_WHITESPACE;
            end
            if (n_kind != KIND_NONE) begin
                if (continues(n_kind, i_byte)) begin
                    taken = 1'b1;
                end else begin
                    ent.start0 = r_start;
                    ent.end0   = r_pos;
                    cnt        = 2'd1;
                    n_kind     = KIND_NONE;
                end
            end
            if (!taken) begin
                n_start = r_pos;
                if (i_byte >= LEAD_MIN) begin
                    n_kind = KIND_UTF8;
                    n_left = (i_byte >= LEAD4_MIN) ? 2'd3 :
                             (i_byte >= LEAD3_MIN) ? 2'd2 : 2'd1;
                end else if (i_byte == CH_SPACE) begin
                    if (i_eot) begin
                        if (cnt == 2'd0) begin
                            ent.start0 = r_pos;
                            ent.end0   = pe;
                        end else begin
                            ent.start1 = r_pos;
                            ent.end1   = pe;
                        end
                        cnt = cnt + 2'd1;
                    end else begin
                        n_space = 1'b1;
                    end
                end else if (is_space_class(i_byte)) begin
                    n_kind = KIND_WHITESPACE;
                end else if (is_alpha_byte(i_byte) || i_byte == CH_APOS) begin
                    n_kind = KIND_LETTERS;
                end else if (is_digit(i_byte)) begin
                    if (cnt == 2'd0) begin
                        ent.start0 = r_pos;
                        ent.end0   = pe;
                    end else begin
                        ent.start1 = r_pos;
                        ent.end1   = pe;
                    end
                    cnt = cnt + 2'd1;
                end else begin
                    n_kind = KIND_OTHER;
                end
            end
        end

        if (i_eot) begin
            if (n_kind != KIND_NONE && cnt < 2'd2) begin
                if (cnt == 2'd0) begin
                    ent.start0 = n_start;
                    ent.end0   = pe;
                end else begin
                    ent.start1 = n_start;
                    ent.end1   = pe;
                end
                cnt = cnt + 2'd1;
            end
            n_pos   = '0;
            n_start = '0;
            n_kind  = KIND_NONE;
            n_left  = 2'd0;
            n_space = 1'b0;
        end else begin
            n_pos = pe;
        end

        ent.two = (cnt == 2'd2);
    end

    assign o_push  = i_accept && (cnt != 2'd0);
    assign o_entry = ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_start <= '0;
            r_kind  <= KIND_NONE;
            r_left  <= 2'd0;
            r_space <= 1'b0;
        end else if (i_accept) begin
            r_pos   <= n_pos;
            r_start <= n_start;
            r_kind  <= n_kind;
            r_left  <= n_left;
            r_space <= n_space;
        end
    end

endmodule

// ===== hw/rtl/bpt_queue.sv =====
// Short queue of range entries between the front end and the output stage.
// Shows the head entry without a read delay. Depends on bpt_pkg.
module bpt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bpt_pkg::t_entry i_entry,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output bpt_pkg::t_entry o_entry
);
    import bpt_pkg::*;

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic [QCNT_W-1:0]   n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("Entry pushed into a full queue.");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("Entry popped from an empty queue.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("Queue count exceeds its depth.");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0 && r_count != QCNT_W'(QUEUE_DEPTH)) |->
            (QPTR_W'(r_wr_ptr - r_rd_ptr) == QPTR_W'(r_count)))
        else $error("Queue pointers disagree with the count.");

endmodule

// ===== hw/rtl/bpt_back.sv =====
// Output stage of the pre-tokenizer: splits each queue entry into range transfers.
// Holds the second range of an entry while the first is sent. Depends on bpt_pkg.
module bpt_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    input  bpt_pkg::t_entry           i_q_entry,
    output logic                      o_q_pop,
    output logic                      o_tvalid,
    input  logic                      i_tready,
    output logic [2*bpt_pkg::POS_W-1:0] o_tdata,
    output logic                      o_tlast
);
    import bpt_pkg::*;

    logic                 r_valid;
    logic [2*POS_W-1:0]   r_data;
    logic                 r_last;
    logic                 r_hold_v;
    logic [2*POS_W-1:0]   r_hold;
    logic                 load;

    assign load    = !r_valid || i_tready;
    assign o_q_pop = load && !r_hold_v && i_q_valid;

    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tlast  = r_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_hold_v) begin
                r_data <= r_hold;
                r_last <= 1'b1;
            end else begin
                r_data <= {i_q_entry.end0, i_q_entry.start0};
                r_last <= !i_q_entry.two;
            end
            if (o_q_pop) begin
                r_hold <= {i_q_entry.end1, i_q_entry.start1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_hold_v <= 1'b0;
        end else if (load) begin
            if (r_hold_v) begin
                r_valid  <= 1'b1;
                r_hold_v <= 1'b0;
            end else begin
                r_valid  <= i_q_valid;
                r_hold_v <= i_q_valid && i_q_entry.two;
            end
        end
    end

    a_hold_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_v |-> (r_valid && !r_last))
        else $error("Second range held without a pending first range.");

    a_no_pop_while_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_v |-> !o_q_pop)
        else $error("Queue popped while a second range is still held.");

    a_last_after_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hold_v && i_tready) |=> (r_valid && r_last))
        else $error("Held range was not sent as the last of its run.");

endmodule

// ===== hw/rtl/byte_level_pretokenizer.sv =====
// Top level of the byte-level pre-tokenizer.
// Connects the front end, the range queue and the output stage. Depends on bpt_pkg.
//
// Input stream: one text byte per transfer on i_s_tdata, with i_s_tlast marking
// the final byte of a text. Output stream: one pre-token range per transfer,
// o_m_tdata = {group_end, group_start}, o_m_tlast set on the last range that a
// byte caused. A byte may cause no range, one range or two ranges.
// Throughput is one byte per cycle while the queue is not full; the front end
// classifies a byte and updates the open group in the cycle it is accepted. The
// output stage sends one range per cycle while the receiver is ready, so a byte
// that closes two ranges is sent as two transfers. A range is written into the
// queue when its byte is accepted, then loaded into the output register once
// that register is free, and held on the output until the receiver takes it.
// When the receiver stalls, ranges collect in a four-entry queue; input is held
// off only once that queue is full. A space is held until the next byte, so
// its range may appear one byte late. After the final byte of a text all
// state returns to offset zero. Reset empties the queue and the output stage.
module byte_level_pretokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] text_byte
    input  logic        i_s_tlast,   // end_of_text
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [15:0] group_start, [31:16] group_end
    output logic        o_m_tlast    // last_of_run
);
    import bpt_pkg::*;

    logic   accept;
    logic   push;
    logic   q_full;
    logic   q_valid;
    logic   q_pop;
    t_entry push_entry;
    t_entry head_entry;

    assign o_s_tready = !q_full;
    assign accept     = i_s_tvalid && o_s_tready;

    bpt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_tdata),
        .i_eot    (i_s_tlast),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    bpt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_entry (head_entry)
    );

    bpt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (head_entry),
        .o_q_pop   (q_pop),
        .o_tvalid  (o_m_tvalid),
        .i_tready  (i_m_tready),
        .o_tdata   (o_m_tdata),
        .o_tlast   (o_m_tlast)
    );

endmodule

// ===== sim/tb_byte_level_pretokenizer.sv =====
// Self-checking testbench for byte_level_pretokenizer: streams texts through the
// block and checks every emitted pre-token range against an in-bench predictor.
// Depends on bpt_pkg and the byte_level_pretokenizer RTL.
`timescale 1ns / 100ps

module tb_byte_level_pretokenizer;
    import bpt_pkg::*;

    localparam logic [7:0] LEAD_MIN  = 8'h80;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD4_MIN = 8'hF0;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam int RANDOM_BYTES = 380;
    localparam int LONG_RUN     = 32;

    typedef struct {
        logic [7:0] data;
        logic       eot;
        int         gap;
        bit         drain;
        bit         quiet;
    } t_text_byte;

    typedef struct {
        t_pos start_pos;
        t_pos end_pos;
        logic tail;
    } t_range;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = '0;   // [7:0] text_byte
    logic        i_s_tlast = 1'b0; // end_of_text
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;        // [15:0] group_start, [31:16] group_end
    logic        o_m_tlast;        // last_of_run

    t_text_byte text_q[$];
    t_range     range_q[$];
    int         err_cnt = 0;
    bit         rx_quiet = 1'b0;
    bit         armed = 1'b0;
    int         wait_left = 0;
    int         stall_left = 0;
    t_text_byte head;
    t_range     want;

    int    cur_pos = 0;
    int    grp_start = 0;
    t_kind grp_kind = KIND_NONE;
    int    cont_left = 0;
    bit    space_held = 1'b0;

    byte_level_pretokenizer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic bit is_alpha(logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    function automatic bit is_ws(logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
    endfunction

    function automatic bit is_num(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    // Updates the group state for one accepted byte and queues the ranges it closes.
    task automatic pretokenize_byte(input logic [7:0] b, input logic eot);
        int p;
        int pe;
        int n;
        int rs[2];
        int re[2];
        bit taken;
        bit joins;
        t_range r;
        p = cur_pos;
        pe = (p >= MAX_TEXT_BYTES) ? MAX_TEXT_BYTES : p + 1;
        n = 0;
        taken = 1'b0;
        joins = 1'b0;
        if (cont_left > 0) begin
            cont_left--;
            if (cont_left == 0) begin
                rs[n] = grp_start;
                re[n] = pe;
                n++;
                grp_kind = KIND_NONE;
            end
        end else begin
            if (space_held) begin
                space_held = 1'b0;
                grp_kind = is_alpha(b) ? KIND_SPACE_LETTERS : KIND_WHITESPACE;
            end
            if (grp_kind != KIND_NONE) begin
                case (grp_kind)
                    KIND_SPACE_LETTERS: joins = is_alpha(b);
                    KIND_WHITESPACE:    joins = is_ws(b);
                    KIND_LETTERS:       joins = is_alpha(b) || b == CH_APOS;
                    KIND_OTHER:         joins = b < LEAD_MIN && !is_ws(b) && !is_alpha(b) &&
                                                b != CH_APOS && !is_num(b);
                    default:            joins = 1'b0;
                endcase
                if (joins) begin
                    taken = 1'b1;
                end else begin
                    rs[n] = grp_start;
                    re[n] = p;
                    n++;
                    grp_kind = KIND_NONE;
                end
            end
            if (!taken) begin
                grp_start = p;
                if (b >= LEAD_MIN) begin
                    grp_kind = KIND_UTF8;
                    cont_left = (b >= LEAD4_MIN) ? 3 : (b >= LEAD3_MIN) ? 2 : 1;
                end else if (b == CH_SPACE) begin
                    if (eot) begin
                        rs[n] = p;
                        re[n] = pe;
                        n++;
                    end else begin
                        space_held = 1'b1;
                    end
                end else if (is_ws(b)) begin
                    grp_kind = KIND_WHITESPACE;
                end else if (is_alpha(b) || b == CH_APOS) begin
                    grp_kind = KIND_LETTERS;
                end else if (is_num(b)) begin
                    rs[n] = p;
                    re[n] = pe;
                    n++;
                end else begin
                    grp_kind = KIND_OTHER;
                end
            end
        end
        if (eot) begin
            if (grp_kind != KIND_NONE && n < 2) begin
                rs[n] = grp_start;
                re[n] = pe;
                n++;
            end
            cur_pos = 0;
            grp_start = 0;
            grp_kind = KIND_NONE;
            cont_left = 0;
            space_held = 1'b0;
        end else begin
            cur_pos = pe;
        end
        for (int k = 0; k < n; k++) begin
            r.start_pos = t_pos'(rs[k]);
            r.end_pos = t_pos'(re[k]);
            r.tail = (k == n - 1);
            range_q.push_back(r);
        end
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom_range(0, 1) ? 8'($urandom_range("a", "z"))
                                                 : 8'($urandom_range("A", "Z"));
            3, 4:    return CH_SPACE;
            5: begin
                case ($urandom_range(0, 2))
                    0:       return CH_TAB;
                    1:       return CH_LF;
                    default: return CH_CR;
                endcase
            end
            6:       return $urandom_range(0, 1) ? CH_APOS : 8'($urandom_range("0", "9"));
            7:       return 8'($urandom_range(8'h21, 8'h2F));
            8:       return 8'($urandom_range(LEAD_MIN, 8'hFF));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_text(input logic [7:0] bytes[$], input bit quiet, input bit drain);
        t_text_byte t;
        foreach (bytes[i]) begin
            t.data = bytes[i];
            t.eot = (i == bytes.size() - 1);
            t.gap = quiet ? 0 : $urandom_range(0, 4);
            t.drain = drain && (i == 0);
            t.quiet = quiet;
            text_q.push_back(t);
        end
    endtask

    initial begin
        logic [7:0] bytes[$];
        int n_rand;
        int len;
        bytes = '{CH_SPACE};
        queue_text(bytes, 1'b0, 1'b0);
        bytes = '{"A", CH_APOS, "z", CH_SPACE, "b", CH_SPACE, CH_SPACE, CH_TAB, CH_LF, CH_CR,
                  "0", "9", "!", 8'h7F, 8'h00, 8'h80, 8'hFF, 8'hE2, 8'h41, 8'h00,
                  8'hF7, 8'h80};
        queue_text(bytes, 1'b0, 1'b0);
        bytes = '{"x", CH_SPACE};
        queue_text(bytes, 1'b1, 1'b0);

        // One longer text with a letter run followed by a mix of groups.
        bytes.delete();
        for (int i = 0; i < LONG_RUN; i++) begin
            bytes.push_back("a");
        end
        bytes.push_back(CH_SPACE);
        bytes.push_back("b");
        bytes.push_back("1");
        bytes.push_back("2");
        bytes.push_back(CH_SPACE);
        bytes.push_back(CH_SPACE);
        bytes.push_back("!");
        bytes.push_back(8'hC5);
        bytes.push_back("q");
        bytes.push_back("7");
        for (int i = 0; i < 8; i++) begin
            bytes.push_back(pick_byte());
        end
        queue_text(bytes, 1'b1, 1'b1);

        n_rand = 0;
        while (n_rand < RANDOM_BYTES) begin
            bytes.delete();
            len = $urandom_range(1, 24);
            for (int i = 0; i < len; i++) begin
                bytes.push_back(pick_byte());
            end
            queue_text(bytes, $urandom_range(0, 3) == 0,
                       n_rand == 0 || $urandom_range(0, 7) == 0);
            n_rand += len;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (text_q.size() > 0 || i_s_tvalid || range_q.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0 && range_q.size() == 0) begin
            $display("[byte_level_pretokenizer] OK");
        end else begin
            $display("[byte_level_pretokenizer] ERROR");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("[byte_level_pretokenizer] ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            armed = 1'b0;
            wait_left = 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                pretokenize_byte(i_s_tdata, i_s_tlast);
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (text_q.size() == 0) begin
                    i_s_tvalid <= 1'b0;
                end else begin
                    if (!armed) begin
                        wait_left = text_q[0].gap;
                        armed = 1'b1;
                    end
                    if (wait_left > 0) begin
                        wait_left--;
                        i_s_tvalid <= 1'b0;
                    end else if (text_q[0].drain && range_q.size() > 0) begin
                        i_s_tvalid <= 1'b0;
                    end else begin
                        head = text_q.pop_front();
                        armed = 1'b0;
                        i_s_tvalid <= 1'b1;
                        i_s_tdata <= head.data;
                        i_s_tlast <= head.eot;
                        rx_quiet <= head.quiet;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (range_q.size() == 0) begin
                    $display("%0t: unexpected range, expected none, got start %0d end %0d last %0d",
                             $time, o_m_tdata[15:0], o_m_tdata[31:16], o_m_tlast);
                    err_cnt++;
                end else begin
                    want = range_q.pop_front();
                    if (o_m_tdata[15:0] !== want.start_pos) begin
                        $display("%0t: group_start expected %0d, got %0d",
                                 $time, want.start_pos, o_m_tdata[15:0]);
                        err_cnt++;
                    end
                    if (o_m_tdata[31:16] !== want.end_pos) begin
                        $display("%0t: group_end expected %0d, got %0d",
                                 $time, want.end_pos, o_m_tdata[31:16]);
                        err_cnt++;
                    end
                    if (o_m_tlast !== want.tail) begin
                        $display("%0t: last_of_run expected %0d, got %0d",
                                 $time, want.tail, o_m_tlast);
                        err_cnt++;
                    end
                end
                stall_left = rx_quiet ? 0 : $urandom_range(0, 4);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

endmodule

// ===== byte_level_pretokenizer.f =====
hw/rtl/bpt_pkg.sv
hw/rtl/bpt_front.sv
hw/rtl/bpt_queue.sv
hw/rtl/bpt_back.sv
hw/rtl/byte_level_pretokenizer.sv
sim/tb_byte_level_pretokenizer.sv
